// ===== src/ssl_pkg.sv =====
// shared widths, register indexes and arctangent table for the stanley steering law
package ssl_pkg;

	localparam int XW  = 36;	// cordic x and y width
	localparam int ZW  = 27;	// cordic angle width, 24 fraction bits
	localparam int PW  = 17;	// wrapped heading error width
	localparam int DW  = 30;	// steering angle width, 2^-24 rad
	localparam int NW  = 36;	// divider numerator width
	localparam int QW  = 16;	// quotient bits
	localparam int GW  = 16;	// gain width
	localparam int MW  = 15;	// max steer angle width

	localparam logic signed [PW-1:0] PI_Q13     = 17'sd25736;
	localparam logic signed [PW-1:0] TWO_PI_Q13 = 17'sd51472;
	localparam logic signed [15:0]   SPEED_MIN  = 16'sd256;
	localparam logic [QW-1:0]        ONE_Q14    = 16'd16384;

	localparam logic [7:0] CFG_GAIN      = 8'd0;
	localparam logic [7:0] CFG_MAX_STEER = 8'd1;

	// atan(2^-i) scaled by 2^24, rounded
	function automatic logic signed [ZW-1:0] atan_lut(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0:  r = 27'sd13176795;
			1:  r = 27'sd7778716;
			2:  r = 27'sd4110060;
			3:  r = 27'sd2086331;
			4:  r = 27'sd1047214;
			5:  r = 27'sd524117;
			6:  r = 27'sd262123;
			7:  r = 27'sd131069;
			8:  r = 27'sd65536;
			9:  r = 27'sd32768;
			10: r = 27'sd16384;
			11: r = 27'sd8192;
			12: r = 27'sd4096;
			13: r = 27'sd2048;
			14: r = 27'sd1024;
			15: r = 27'sd512;
			16: r = 27'sd256;
			17: r = 27'sd128;
			18: r = 27'sd64;
			19: r = 27'sd32;
			20: r = 27'sd16;
			21: r = 27'sd8;
			22: r = 27'sd4;
			23: r = 27'sd2;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== src/stanley_steering_law_top.sv =====
// stanley steering law: heading wrap, cordic arctangent, rounding divider and clamp
// throughput: one request per cycle; the whole pipe advances together and holds on a stall
// the pipe is the stage 1 register, one cordic stage per iteration, two divider set-up
// stages, then one restoring divider stage per quotient bit and the output register
// reset: asynchronous active low; clears all valid bits, gain to 1.0 and max steer angle to 1.0
// configuration writes are always ready and are meant only while the pipe is empty
module stanley_steering_law_top #(
	parameter int CORDIC_STEPS = 16	// 8 to 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,	// vehicle_yaw, path_yaw, cross_error, speed
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,	// steer_command
	output logic        m_tuser,	// clamped
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import ssl_pkg::*;

	localparam int NS = CORDIC_STEPS;

	// configuration registers
	logic [GW-1:0] gain_q;
	logic [MW-1:0] max_steer_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q      <= 16'd256;
			max_steer_q <= 15'd8192;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_GAIN)           gain_q      <= cfg_data;
			else if (cfg_index == CFG_MAX_STEER) max_steer_q <= cfg_data[MW-1:0];
		end
	end

	// whole pipe moves when the output slot is free or being taken
	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// stage 1: heading wrap, speed floor, cordic start vector
	logic signed [15:0] vy, py, err, spd;
	logic signed [PW-1:0] diff, psi;
	logic signed [15:0] spd_f;

	assign vy  = s_tdata[15:0];
	assign py  = s_tdata[31:16];
	assign err = s_tdata[47:32];
	assign spd = s_tdata[63:48];

	always_comb begin
		diff = PW'(py) - PW'(vy);
		if (diff > PI_Q13)        psi = diff - TWO_PI_Q13;
		else if (diff <= -PI_Q13) psi = diff + TWO_PI_Q13;
		else                      psi = diff;
		spd_f = (spd < SPEED_MIN) ? SPEED_MIN : spd;
	end

	// cordic pipe, index 0 is the stage 1 register
	logic                 cv_s   [NS+1];
	logic signed [XW-1:0] cx_s   [NS+1];
	logic signed [XW-1:0] cy_s   [NS+1];
	logic signed [ZW-1:0] cz_s   [NS+1];
	logic signed [PW-1:0] cpsi_s [NS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)  cv_s[0] <= 1'b0;
		else if (adv) cv_s[0] <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s[0]   <= XW'({spd_f, 8'd0});
			cy_s[0]   <= XW'($signed({1'b0, gain_q}) * err);
			cz_s[0]   <= '0;
			cpsi_s[0] <= psi;
		end
	end

	// vectoring iterations, one per stage, shifts round toward minus infinity
	for (genvar i = 0; i < NS; i++) begin : g_cordic
		logic signed [XW-1:0] xs, ys;
		assign xs = cx_s[i] >>> i;
		assign ys = cy_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)  cv_s[i+1] <= 1'b0;
			else if (adv) cv_s[i+1] <= cv_s[i];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (!cy_s[i][XW-1]) begin
					cx_s[i+1] <= cx_s[i] + ys;
					cy_s[i+1] <= cy_s[i] - xs;
					cz_s[i+1] <= cz_s[i] + atan_lut(i);
				end else begin
					cx_s[i+1] <= cx_s[i] - ys;
					cy_s[i+1] <= cy_s[i] + xs;
					cz_s[i+1] <= cz_s[i] - atan_lut(i);
				end
				cpsi_s[i+1] <= cpsi_s[i];
			end
		end
	end

	// first set-up stage: steering angle, sign and magnitude
	logic signed [DW-1:0] delta;
	logic signed [DW+2:0] num;

	always_comb begin
		delta = (DW'(cpsi_s[NS]) <<< 11) + DW'(cz_s[NS]);
		num   = (DW+3)'(delta) <<< 3;
	end

	logic          mv_s;
	logic [DW+2:0] mag_s;
	logic          mneg_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)  mv_s <= 1'b0;
		else if (adv) mv_s <= cv_s[NS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s  <= num[DW+2] ? (DW+3)'(-num) : (DW+3)'(num);
			mneg_s <= num[DW+2];
		end
	end

	// second set-up stage: rounding numerator and overflow check
	logic [NW-1:0] nrnd, dfull;

	always_comb begin
		nrnd  = (NW'(mag_s) << 1) + NW'(max_steer_q);
		dfull = NW'(max_steer_q) << (QW + 1);
	end

	// divider pipe, index 0 holds the set-up result
	logic          dv_s   [QW+1];
	logic [NW-1:0] dr_s   [QW+1];
	logic [QW-1:0] dq_s   [QW+1];
	logic [MW:0]   dd_s   [QW+1];	// twice the full scale
	logic          dneg_s [QW+1];
	logic          dovf_s [QW+1];
	logic          dzero_s[QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)  dv_s[0] <= 1'b0;
		else if (adv) dv_s[0] <= mv_s;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dr_s[0]    <= nrnd;
			dq_s[0]    <= '0;
			dd_s[0]    <= {max_steer_q, 1'b0};
			dneg_s[0]  <= mneg_s;
			dovf_s[0]  <= (nrnd >= dfull);
			dzero_s[0] <= (max_steer_q == '0);
		end
	end

	// restoring division, one quotient bit per stage from the top
	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [NW-1:0] dsh;
		logic          fit;
		assign dsh = NW'(dd_s[k]) << (QW - 1 - k);
		assign fit = (dr_s[k] >= dsh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)  dv_s[k+1] <= 1'b0;
			else if (adv) dv_s[k+1] <= dv_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dr_s[k+1]    <= fit ? dr_s[k] - dsh : dr_s[k];
				dq_s[k+1]    <= dq_s[k] | (fit ? QW'(1) << (QW - 1 - k) : '0);
				dd_s[k+1]    <= dd_s[k];
				dneg_s[k+1]  <= dneg_s[k];
				dovf_s[k+1]  <= dovf_s[k];
				dzero_s[k+1] <= dzero_s[k];
			end
		end
	end

	// output stage: clamp to plus or minus one, restore sign, zero full scale gives zero
	logic [QW-1:0] qmag;
	logic          sat;
	logic [15:0]   cmd;

	always_comb begin
		sat  = !dzero_s[QW] && (dovf_s[QW] || dq_s[QW] > ONE_Q14);
		qmag = dzero_s[QW] ? '0 : (sat ? ONE_Q14 : dq_s[QW]);
		cmd  = dneg_s[QW] ? 16'(-qmag) : qmag;
	end

	logic        ov_s;
	logic [15:0] ocmd_s;
	logic        osat_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)  ov_s <= 1'b0;
		else if (adv) ov_s <= dv_s[QW];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ocmd_s <= cmd;
			osat_s <= sat;
		end
	end

	assign m_tvalid = ov_s;
	assign m_tdata  = ocmd_s;
	assign m_tuser  = osat_s;

endmodule

// ===== src/ssl_checker.sv =====
// port checker for the stanley steering law and its bind
module ssl_port_props (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser
);

	// input side is free exactly when the output slot is
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output slot");

	// a clamped result sits at plus or minus one
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == 16'h4000 || m_tdata == 16'hC000))
		else $error("clamped result not at full scale");

	// every result within plus or minus one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata) <= 16'sd16384 && $signed(m_tdata) >= -16'sd16384))
		else $error("result out of range");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

endmodule

bind stanley_steering_law_top ssl_port_props u_ssl_port_props (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== verif/ssl_checker.sv =====
// checker: watches the stanley steering law channels, predicts commands and compares
module ssl_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	input  logic        m_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import ssl_pkg::*;

	typedef struct packed {
		logic [15:0] steer;
		logic        clamped;
	} steer_t;

	localparam int STEPS = 16;

	logic [15:0] gain_q;
	logic [14:0] max_q;
	steer_t      steer_q[$];

	assign pending = steer_q.size();

	function automatic longint floor_shift(longint v, int s);
		if (v >= 0) return v >>> s;
		return -(((-v) - 1) >>> s) - 1;
	endfunction

	function automatic longint atan_of(longint x, longint y);
		longint z, xs, ys;
		z = 0;
		for (int i = 0; i < STEPS; i++) begin
			xs = floor_shift(x, i);
			ys = floor_shift(y, i);
			if (y >= 0) begin
				x = x + ys; y = y - xs; z += atan_lut(i);
			end else begin
				x = x - ys; y = y + xs; z -= atan_lut(i);
			end
		end
		return z;
	endfunction

	function automatic steer_t steer_of(logic [63:0] d);
		int vy, py, err, spd, psi;
		longint delta, num, mag, q;
		steer_t r;
		vy  = $signed(d[15:0]);
		py  = $signed(d[31:16]);
		err = $signed(d[47:32]);
		spd = $signed(d[63:48]);
		psi = py - vy;
		if (psi > 25736) psi -= 51472;
		else if (psi <= -25736) psi += 51472;
		if (spd < 256) spd = 256;
		delta = longint'(psi) * 2048 + atan_of(longint'(spd) * 256, longint'(gain_q) * err);
		q = 0;
		r.clamped = 1'b0;
		if (max_q != 0) begin
			num = delta * 8;
			mag = num < 0 ? -num : num;
			q = (2 * mag + max_q) / (2 * longint'(max_q));
			if (q > 16384) begin
				q = 16384; r.clamped = 1'b1;
			end
			if (num < 0) q = -q;
		end
		r.steer = q[15:0];
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch: %s", what);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		steer_t e;
		if (!arst_n) begin
			gain_q = 16'd256;
			max_q = 15'd8192;
			fail_count = 0;
			steer_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_GAIN) gain_q = cfg_data;
				else if (cfg_index == CFG_MAX_STEER) max_q = cfg_data[14:0];
			end
			if (s_tvalid && s_tready) steer_q.push_back(steer_of(s_tdata));
			if (m_tvalid && m_tready) begin
				if (steer_q.size() == 0) report_mismatch("result with no request pending");
				else begin
					e = steer_q.pop_front();
					if (m_tdata !== e.steer)
						report_mismatch($sformatf("steer %0d want %0d",
							$signed(m_tdata), $signed(e.steer)));
					if (m_tuser !== e.clamped)
						report_mismatch($sformatf("clamped %0b want %0b", m_tuser, e.clamped));
				end
			end
		end
	end
endmodule

// ===== verif/tb_top.sv =====
// testbench top: stimulus for the stanley steering law and the final verdict
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ssl_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;	// vehicle_yaw, path_yaw, cross_error, speed
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;	// steer_command
	logic        m_tuser;	// clamped
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	int          fail_count, pending;
	bit          hold_off = 1'b0;	// long receiver stall, set by the stimulus

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	stanley_steering_law_top dut (.*);
	ssl_checker chk (.*);

	// receiver: stalls on its own rhythm, except long hold-offs and clean stretches
	initial begin
		int mode;
		mode = 0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
			if (hold_off) m_tready <= 1'b0;
			else case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= $urandom_range(0, 3) != 0;
				2: m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= $urandom_range(0, 7) == 0;
			endcase
		end
	end

	// one request, after a gap in a burst pattern; returns at the falling edge after acceptance
	int burst_left = 0;
	task automatic send_sample(logic [15:0] vy, py, err, spd);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {spd, err, py, vy};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic drain_pipe();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending != 0) @(negedge clk);
		repeat (45) @(negedge clk);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// yaw mostly in range, sometimes any 16 bit pattern
	function automatic logic [15:0] rand_yaw();
		if ($urandom_range(0, 9) == 0) return 16'($urandom);
		return 16'($urandom_range(0, 51472) - 25736);
	endfunction

	function automatic logic [15:0] rand_q88();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 2048) - 1024);
			2: return 16'($urandom_range(0, 511));
			default: return 16'($urandom_range(0, 8191) - 4096);
		endcase
	endfunction

	initial begin
		logic [15:0] gains[6];
		logic [15:0] maxes[6];
		gains = '{16'd256, 16'd0, 16'd65535, 16'd1, 16'd1024, 16'hFFFF};
		maxes = '{16'd8192, 16'd0, 16'd25736, 16'd1, 16'h7FFF, 16'hFFFF};
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes, heading wrap both ways, speed floor, reset registers
		send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0);
		send_sample(-16'sd25736, 16'sd25736, 16'sd0, 16'sd256);
		send_sample(16'sd25736, -16'sd25736, 16'sd0, 16'sd256);
		send_sample(16'sd25736, 16'sd0, 16'sd0, 16'sd256);
		send_sample(16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_sample(16'h7FFF, 16'h8000, 16'h8000, 16'h8000);
		send_sample(16'sd0, 16'sd100, 16'sd256, 16'sd255);
		send_sample(16'sd0, -16'sd100, -16'sd256, -16'sd1);
		send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_sample(16'sd0, 16'sd0, 16'h7FFF, 16'sd256);
		send_sample(16'sd0, 16'sd0, 16'h8000, 16'sd256);
		drain_pipe();
		write_reg(CFG_GAIN, 16'hFFFF);
		write_reg(CFG_MAX_STEER, 16'd0);
		write_reg(8'd2, 16'h1234);	// index out of range, ignored
		send_sample(16'sd0, 16'sd25000, 16'h7FFF, 16'sd256);
		send_sample(16'sd0, 16'sd0, 16'h8000, 16'sd300);
		drain_pipe();
		write_reg(CFG_MAX_STEER, 16'hFFFF);	// top bit masked
		send_sample(16'sd0, 16'sd25000, 16'h7FFF, 16'sd256);
		send_sample(16'sd100, -16'sd25000, 16'h8000, 16'h7FFF);
		drain_pipe();
		write_reg(CFG_MAX_STEER, 16'd1);
		send_sample(16'sd0, 16'sd1, 16'sd0, 16'sd256);
		send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd256);

		// random phases across register settings
		for (int ph = 0; ph < 12; ph++) begin
			drain_pipe();
			write_reg(CFG_GAIN, ph < 6 ? gains[ph] : 16'($urandom));
			write_reg(CFG_MAX_STEER, ph < 6 ? maxes[ph] : 16'($urandom_range(1, 25736)));
			for (int n = 0; n < 110; n++) begin
				if (ph == 3 && n == 20) begin
					// long stall at the output while requests keep coming
					hold_off = 1'b1;
					fork
						begin
							repeat (150) @(negedge clk);
							hold_off = 1'b0;
						end
					join_none
				end
				send_sample(rand_yaw(), rand_yaw(), rand_q88(), rand_q88());
			end
		end
		drain_pipe();
		if (fail_count == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// ===== stanley_steering_law_top.f =====
src/ssl_pkg.sv
src/stanley_steering_law_top.sv
src/ssl_checker.sv
verif/ssl_checker.sv
verif/tb_top.sv
